[design/pdc_pkg.sv]
`default_nettype none

package pdc_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned POS_W       = 11;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned MAX_PAYLOAD = 1024;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] END_BYTE   = 8'h7F;

  typedef enum logic [KIND_W-1:0] {
    EV_PAYLOAD = 2'd0,
    EV_GOOD    = 2'd1,
    EV_CSUM    = 2'd2
  } event_kind_t;

  typedef enum logic [4:0] {
    PH_HUNT     = 5'b00001,
    PH_LEN      = 5'b00010,
    PH_DATA     = 5'b00100,
    PH_WAIT_END = 5'b01000,
    PH_ERROR    = 5'b10000
  } phase_t;

endpackage

`default_nettype wire

[design/packet_deframer_checksum_core.sv]
`default_nettype none

// channel | handshake            | payload
// --------+----------------------+--------------------------------------
// in      | in_valid / in_ready  | rx_byte
// out     | out_valid / out_ready| event_kind, byte_value, position
//
// one byte is taken per cycle while in_ready is high; the parser state and the result register
// update together at the edge that accepts the byte
// a result appears in the cycle after its byte is accepted and holds until taken
// in_ready is high while the result register is empty or being drained
// rst is synchronous and returns the parser to hunting for a start byte

module packet_deframer_checksum_core #(
  parameter int unsigned MAX_PAYLOAD = pdc_pkg::MAX_PAYLOAD
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [pdc_pkg::BYTE_W-1:0]  rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [pdc_pkg::KIND_W-1:0]       event_kind,
  output logic [pdc_pkg::BYTE_W-1:0]       byte_value,
  output logic [pdc_pkg::POS_W-1:0]        position
);
  import pdc_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_PAYLOAD + 1);

  phase_t               phase, phase_next;
  logic [LEN_W-1:0]     frame_length, frame_length_next;
  logic [IDX_W-1:0]     byte_index, byte_index_next;
  logic                 len_hi, len_hi_next;
  logic [BYTE_W-1:0]    running_sum, running_sum_next;
  logic [BYTE_W-1:0]    first_payload, first_payload_next;

  logic                 res_valid;
  logic [KIND_W-1:0]    res_kind;
  logic [BYTE_W-1:0]    res_value;
  logic [POS_W-1:0]     res_pos;

  logic                 accept;
  logic [LEN_W-1:0]     new_length;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign new_length = {rx_byte, frame_length[BYTE_W-1:0]};

  always_comb begin
    phase_next         = phase;
    frame_length_next  = frame_length;
    byte_index_next    = byte_index;
    len_hi_next        = len_hi;
    running_sum_next   = running_sum;
    first_payload_next = first_payload;
    res_valid          = 1'b0;
    res_kind           = EV_PAYLOAD;
    res_value          = '0;
    res_pos            = '0;
    unique case (phase)
      PH_LEN: begin
        running_sum_next = running_sum + rx_byte;
        if (!len_hi) begin
          len_hi_next       = 1'b1;
          frame_length_next = {{(LEN_W-BYTE_W){1'b0}}, rx_byte};
        end else begin
          len_hi_next       = 1'b0;
          frame_length_next = new_length;
          byte_index_next   = '0;
          if (32'(new_length) > 32'(MAX_PAYLOAD)) begin
            phase_next = PH_HUNT;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (LEN_W'(byte_index) < frame_length) begin
          if (byte_index == '0) begin
            first_payload_next = rx_byte;
          end
          running_sum_next = running_sum + rx_byte;
          byte_index_next  = byte_index + IDX_W'(1);
          res_valid        = 1'b1;
          res_kind         = EV_PAYLOAD;
          res_value        = rx_byte;
          res_pos          = POS_W'(byte_index);
        end else if (running_sum == rx_byte) begin
          phase_next = PH_WAIT_END;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_WAIT_END: begin
        byte_index_next = '0;
        if (rx_byte == END_BYTE) begin
          phase_next = PH_HUNT;
          res_valid  = 1'b1;
          res_kind   = EV_GOOD;
          res_pos    = frame_length[POS_W-1:0];
        end
      end
      PH_ERROR: begin
        phase_next        = PH_HUNT;
        frame_length_next = '0;
        byte_index_next   = '0;
        res_valid         = 1'b1;
        res_kind          = EV_CSUM;
        res_value         = first_payload;
        res_pos           = frame_length[POS_W-1:0];
      end
      default: begin
        phase_next      = PH_HUNT;
        byte_index_next = '0;
        len_hi_next     = 1'b0;
        if (rx_byte == START_BYTE) begin
          phase_next         = PH_LEN;
          frame_length_next  = '0;
          running_sum_next   = '0;
          first_payload_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      frame_length  <= '0;
      byte_index    <= '0;
      len_hi        <= 1'b0;
      running_sum   <= '0;
      first_payload <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        frame_length  <= frame_length_next;
        byte_index    <= byte_index_next;
        len_hi        <= len_hi_next;
        running_sum   <= running_sum_next;
        first_payload <= first_payload_next;
        out_valid     <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded only with a new transaction
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      event_kind <= res_kind;
      byte_value <= res_value;
      position   <= res_pos;
    end
  end

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
  import pdc_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TOTAL_BYTES = 1200;

  typedef struct packed {
    event_kind_t          kind;
    logic [BYTE_W-1:0]    value;
    logic [POS_W-1:0]     pos;
  } parser_event_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [BYTE_W-1:0]   rx_byte;
  logic                out_valid;
  logic                out_ready;
  logic [KIND_W-1:0]   event_kind;
  logic [BYTE_W-1:0]   byte_value;
  logic [POS_W-1:0]    position;

  packet_deframer_checksum_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .byte_value (byte_value),
    .position   (position)
  );

  always #1 clk = ~clk;

  // parser state as the frame decoder should see it
  phase_t              parse_phase = PH_HUNT;
  logic [LEN_W-1:0]    parse_len   = '0;
  logic [POS_W-1:0]    parse_idx   = '0;
  logic [BYTE_W-1:0]   parse_sum   = '0;
  logic [BYTE_W-1:0]   parse_first = '0;

  parser_event_t       pending_events[$];

  bit                  in_idle  = 1'b1;
  bit                  out_idle = 1'b1;
  int                  mismatches   = 0;
  int                  bytes_sent   = 0;
  int                  framed_bytes = 0;
  int                  n_payload    = 0;
  int                  n_good       = 0;
  int                  n_csum       = 0;
  int                  quiet_cycles = 0;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void predict_events(input logic [BYTE_W-1:0] b);
    parser_event_t ev;
    if (parse_phase != PH_HUNT) framed_bytes++;
    case (parse_phase)
      PH_LEN: begin
        parse_idx = parse_idx + 1'b1;
        parse_sum = parse_sum + b;
        if (parse_idx == 1) begin
          parse_len = {8'h00, b};
        end else begin
          parse_len   = {b, parse_len[7:0]};
          parse_phase = (parse_len > MAX_PAYLOAD) ? PH_HUNT : PH_DATA;
          parse_idx   = '0;
        end
      end
      PH_DATA: begin
        if (parse_idx < parse_len) begin
          if (parse_idx == 0) parse_first = b;
          parse_sum = parse_sum + b;
          ev = '{EV_PAYLOAD, b, parse_idx};
          pending_events.push_back(ev);
          parse_idx = parse_idx + 1'b1;
        end else begin
          parse_phase = (parse_sum == b) ? PH_WAIT_END : PH_ERROR;
        end
      end
      PH_WAIT_END: begin
        parse_idx = '0;
        if (b == END_BYTE) begin
          parse_phase = PH_HUNT;
          ev = '{EV_GOOD, 8'h00, parse_len[POS_W-1:0]};
          pending_events.push_back(ev);
        end
      end
      PH_ERROR: begin
        ev = '{EV_CSUM, parse_first, parse_len[POS_W-1:0]};
        pending_events.push_back(ev);
        parse_phase = PH_HUNT;
        parse_len   = '0;
        parse_idx   = '0;
      end
      default: begin
        parse_phase = PH_HUNT;
        if (b == START_BYTE) begin
          parse_phase = PH_LEN;
          parse_len   = '0;
          parse_sum   = '0;
          parse_first = '0;
        end
        parse_idx = '0;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = in_idle ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    bytes_sent++;
    predict_events(b);
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // start byte, length; for a length within MAX_PAYLOAD also payload, checksum,
  // then either junk and end byte, or one byte consumed after the bad checksum
  task automatic send_frame(input logic [LEN_W-1:0] len, input bit sum_ok,
                            input int junk, input logic [BYTE_W-1:0] err_byte);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    send_byte(START_BYTE);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    sum = len[7:0] + len[15:8];
    if (len <= MAX_PAYLOAD) begin
      for (int i = 0; i < len; i++) begin
        b = pick_byte();
        sum = sum + b;
        send_byte(b);
      end
      if (sum_ok) begin
        send_byte(sum);
        for (int i = 0; i < junk; i++) begin
          b = (i == 0) ? START_BYTE : 8'($urandom);
          if (b == END_BYTE) b = 8'h00;
          send_byte(b);
        end
        send_byte(END_BYTE);
      end else begin
        b = 8'($urandom_range(1, 255));
        send_byte(sum + b);
        send_byte(err_byte);
      end
    end
  endtask

  task automatic test_good_frames();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(END_BYTE);
    send_frame(16'd2, 1'b1, 1, 8'h00);
    send_frame(16'd1, 1'b1, 0, 8'h00);
  endtask

  task automatic test_empty_frames();
    send_frame(16'd0, 1'b1, 0, 8'h00);
    send_frame(16'd0, 1'b0, 0, START_BYTE);
  endtask

  task automatic test_checksum_errors();
    send_frame(16'd3, 1'b0, 0, END_BYTE);
  endtask

  task automatic test_oversize_length();
    send_frame(LEN_W'(MAX_PAYLOAD + 1), 1'b1, 0, 8'h00);
    send_byte(8'h01);
    send_frame(16'hFFFF, 1'b1, 0, 8'h00);
  endtask

  task automatic test_max_length_frame();
    send_frame(LEN_W'(MAX_PAYLOAD), 1'b1, 0, 8'h00);
  endtask

  task automatic test_random_traffic();
    int pick;
    logic [LEN_W-1:0] len;
    while (bytes_sent < TOTAL_BYTES) begin
      if ($urandom_range(0, 39) == 0) begin
        in_idle  = ($urandom_range(0, 1) == 1);
        out_idle = ($urandom_range(0, 1) == 1);
      end
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        len = ($urandom_range(0, 15) == 0) ? LEN_W'($urandom_range(0, 64))
                                           : LEN_W'($urandom_range(0, 12));
        send_frame(len, $urandom_range(0, 4) != 0, $urandom_range(0, 2), 8'($urandom));
      end else if (pick == 7) begin
        len = ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                          : LEN_W'($urandom_range(MAX_PAYLOAD + 1, 65535));
        send_frame(len, 1'b1, 0, 8'h00);
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        send_byte(START_BYTE);
        repeat ($urandom_range(0, 6)) send_byte(8'($urandom));
      end
    end
    in_idle  = 1'b1;
    out_idle = 1'b1;
  endtask

  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = out_idle ? $urandom_range(0, 15) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_events
    parser_event_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_events.size() == 0) begin
        report($sformatf("unexpected event kind %0d value %0d position %0d",
                         event_kind, byte_value, position));
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind)
          report($sformatf("event_kind %0d, expected %0d", event_kind, want.kind));
        if (byte_value !== want.value)
          report($sformatf("byte_value %0d, expected %0d", byte_value, want.value));
        if (position !== want.pos)
          report($sformatf("position %0d, expected %0d", position, want.pos));
        case (want.kind)
          EV_PAYLOAD: n_payload++;
          EV_GOOD:    n_good++;
          default:    n_csum++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    rx_byte  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_good_frames();
    test_empty_frames();
    test_checksum_errors();
    test_oversize_length();
    test_max_length_frame();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes (%0d inside frames)", bytes_sent, framed_bytes);
    $display("checked %0d payload bytes, %0d good frames, %0d checksum errors",
             n_payload, n_good, n_csum);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
